>>> hdl/sipf_pkg.sv
// Shared types and constants for the servo instruction packet framer.
package sipf_pkg;

	localparam logic [7:0] START_BYTE  = 8'hFF;
	localparam logic [7:0] LEN_OFFSET  = 8'd2;
	localparam int         QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [7:0] servo_id;
		logic [7:0] instruction;
		logic [7:0] param_count;
		logic [7:0] param_byte;
	} req_item_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       end_of_run;
		logic       end_of_packet;
	} tx_item_t;

	// One classified item, as handed from the front to the byte sequencer.
	typedef struct packed {
		logic       hdr;
		logic       has_param;
		logic       has_csum;
		logic [7:0] servo_id;
		logic [7:0] length;
		logic [7:0] instruction;
		logic [7:0] param_byte;
		logic [7:0] csum;
	} cmd_t;

endpackage

>>> hdl/servo_instruction_packet_framer.sv
// Servo-bus instruction packet framer: top level joining front end, queue and byte sequencer.
// Each accepted item becomes a run of bytes on tx: a packet's first item gives the two
// 0xFF start bytes, id, length (count + 2), instruction, the first parameter if the count
// is nonzero, and the checksum if the packet closes there (6 or 7 bytes); each later item
// gives its parameter byte plus the checksum on the last one (1 or 2 bytes). Bytes leave
// at one per clock from the sequencer while the queue holds commands and tx_ready allows.
// The first byte of an item passes through the command queue and then the sequencer's
// output register. Items are taken every cycle while the command queue has room (QueueDepth
// entries), so the input side keeps moving while the output stalls, until the queue fills.
module servo_instruction_packet_framer #(
	parameter int QueueDepth = sipf_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  sipf_pkg::req_item_t req_data,
	output logic                tx_valid,
	input  logic                tx_ready,
	output sipf_pkg::tx_item_t  tx_data
);
	import sipf_pkg::*;

	logic push;
	logic full;
	logic pop;
	logic head_valid;
	cmd_t wr_cmd;
	cmd_t head_cmd;

	sipf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.push      (push),
		.cmd       (wr_cmd),
		.full      (full)
	);

	sipf_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_cmd   (wr_cmd),
		.full     (full),
		.rd_valid (head_valid),
		.rd_cmd   (head_cmd),
		.pop      (pop)
	);

	sipf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (head_valid),
		.cmd       (head_cmd),
		.pop       (pop),
		.tx_valid  (tx_valid),
		.tx_ready  (tx_ready),
		.tx_data   (tx_data)
	);

endmodule

>>> hdl/sipf_front.sv
// Front end: accepts items, tracks packet state and builds byte-sequencer commands.
module sipf_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  sipf_pkg::req_item_t  req_data,
	output logic                 push,
	output sipf_pkg::cmd_t       cmd,
	input  logic                 full
);
	import sipf_pkg::*;

	logic       in_packet_q;
	logic [7:0] params_left_q;
	logic [7:0] sum_q;

	logic [7:0] len;
	logic [7:0] hdr_sum;
	logic [7:0] base_sum;
	logic [7:0] par_sum;
	logic [7:0] base_left;
	logic [7:0] left;
	logic       zero_cnt;
	logic       closes;

	assign req_ready = !full;
	assign push      = req_valid && req_ready;

	assign len       = req_data.param_count + LEN_OFFSET;
	assign hdr_sum   = req_data.servo_id + len + req_data.instruction;
	assign zero_cnt  = (req_data.param_count == 8'd0);
	assign base_sum  = in_packet_q ? sum_q : hdr_sum;
	assign base_left = in_packet_q ? params_left_q : req_data.param_count;
	assign par_sum   = base_sum + req_data.param_byte;
	assign left      = base_left - 8'd1;
	assign closes    = (!in_packet_q && zero_cnt) || (left == 8'd0);

	always_comb begin
		cmd             = '0;
		cmd.hdr         = !in_packet_q;
		cmd.has_param   = in_packet_q || !zero_cnt;
		cmd.has_csum    = closes;
		cmd.servo_id    = req_data.servo_id;
		cmd.length      = len;
		cmd.instruction = req_data.instruction;
		cmd.param_byte  = req_data.param_byte;
		cmd.csum        = (!in_packet_q && zero_cnt) ? ~hdr_sum : ~par_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_packet_q   <= 1'b0;
			params_left_q <= '0;
			sum_q         <= '0;
		end else if (push) begin
			if (closes) begin
				in_packet_q   <= 1'b0;
				params_left_q <= '0;
				sum_q         <= '0;
			end else begin
				in_packet_q   <= 1'b1;
				params_left_q <= left;
				sum_q         <= par_sum;
			end
		end
	end

endmodule

>>> hdl/sipf_queue.sv
// Short command queue between the front end and the byte sequencer.
module sipf_queue #(
	parameter int Depth = sipf_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sipf_pkg::cmd_t  wr_cmd,
	output logic            full,
	output logic            rd_valid,
	output sipf_pkg::cmd_t  rd_cmd,
	input  logic            pop
);
	import sipf_pkg::*;

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	cmd_t          mem_q [Depth];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CW'(Depth));
	assign rd_valid = (count_q != '0);
	assign rd_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> hdl/sipf_back.sv
// Back end: feeds the output register one command byte a cycle unless stalled.
module sipf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  sipf_pkg::cmd_t      cmd,
	output logic                pop,
	output logic                tx_valid,
	input  logic                tx_ready,
	output sipf_pkg::tx_item_t  tx_data
);
	import sipf_pkg::*;

	localparam logic [2:0] ST_SYNC0 = 3'd0;
	localparam logic [2:0] ST_SYNC1 = 3'd1;
	localparam logic [2:0] ST_ID    = 3'd2;
	localparam logic [2:0] ST_LEN   = 3'd3;
	localparam logic [2:0] ST_INS   = 3'd4;
	localparam logic [2:0] ST_PARAM = 3'd5;
	localparam logic [2:0] ST_CSUM  = 3'd6;

	logic       first_q;
	logic [2:0] step_q;
	logic       tx_valid_q;
	tx_item_t   tx_data_q;

	logic [2:0] cur;
	logic [2:0] nxt;
	logic       advance;
	logic       last;
	logic [7:0] sel_byte;

	// first_q: head entry not yet started, its opening step comes from the entry
	assign cur     = first_q ? (cmd.hdr ? ST_SYNC0 : ST_PARAM) : step_q;
	assign advance = cmd_valid && (!tx_valid_q || tx_ready);
	assign last    = (cur == ST_CSUM) || ((cur == ST_PARAM) && !cmd.has_csum);
	assign pop     = advance && last;

	always_comb begin
		nxt      = ST_CSUM;
		sel_byte = START_BYTE;
		unique case (cur)
			ST_SYNC0: begin
				nxt      = ST_SYNC1;
				sel_byte = START_BYTE;
			end
			ST_SYNC1: begin
				nxt      = ST_ID;
				sel_byte = START_BYTE;
			end
			ST_ID: begin
				nxt      = ST_LEN;
				sel_byte = cmd.servo_id;
			end
			ST_LEN: begin
				nxt      = ST_INS;
				sel_byte = cmd.length;
			end
			ST_INS: begin
				nxt      = cmd.has_param ? ST_PARAM : ST_CSUM;
				sel_byte = cmd.instruction;
			end
			ST_PARAM: begin
				nxt      = ST_CSUM;
				sel_byte = cmd.param_byte;
			end
			default: begin
				nxt      = ST_CSUM;
				sel_byte = cmd.csum;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q    <= 1'b1;
			step_q     <= ST_SYNC0;
			tx_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				first_q    <= last;
				step_q     <= nxt;
				tx_valid_q <= 1'b1;
			end else if (tx_ready) begin
				tx_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tx_data_q.tx_byte       <= sel_byte;
			tx_data_q.end_of_run    <= last;
			tx_data_q.end_of_packet <= (cur == ST_CSUM);
		end
	end

	assign tx_valid = tx_valid_q;
	assign tx_data  = tx_data_q;

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cmd_valid)
		else $error("sequencer popped an empty queue");

	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!first_q |-> (step_q != 3'd7))
		else $error("sequencer step out of range");

	a_eop_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (!tx_data_q.end_of_packet || tx_data_q.end_of_run))
		else $error("checksum byte not flagged as end of run");

	a_mid_entry_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!first_q && !advance) |=> ($stable(step_q) && !first_q))
		else $error("sequencer step moved without an output transfer");

endmodule

>>> tb/testbench.sv
// Self-checking bench for the servo instruction packet framer: directed rows and random packets.
`timescale 1ns / 1ps

module testbench;
	import sipf_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 150;
	localparam int STEADY_ITEMS = 40;
	localparam int STALL_PCT    = 37;
	localparam int SETTLE       = 20;

	localparam logic [7:0] INS_PING   = 8'd1;
	localparam logic [7:0] INS_READ   = 8'd2;
	localparam logic [7:0] INS_WRITE  = 8'd3;
	localparam logic [7:0] INS_REG    = 8'd4;
	localparam logic [7:0] INS_ACTION = 8'd5;

	// nbytes of zero: bytes come from the predictor; otherwise they are given here,
	// left-justified, and the last one closes both the run and the packet
	typedef struct packed {
		req_item_t   req;
		logic [2:0]  nbytes;
		logic [55:0] bytes;
	} stim_row_t;

	localparam stim_row_t STIM_ROWS [14] = '{
		{8'h01, INS_PING,  8'h00, 8'hAA, 3'd6, 56'hFFFF_0102_01FB_00},
		{8'hFF, 8'hFF,     8'h00, 8'hFF, 3'd6, 56'hFFFF_FF02_FFFF_00},
		{8'h00, 8'h00,     8'h00, 8'h00, 3'd6, 56'hFFFF_0002_00FD_00},
		{8'h00, INS_WRITE, 8'h01, 8'h55, 3'd7, 56'hFFFF_0003_0355_A4},
		{8'h07, INS_WRITE, 8'h02, 8'h10, 3'd0, 56'h0},
		{8'hFF, 8'hFF,     8'hFF, 8'h20, 3'd0, 56'h0},
		{8'hFE, INS_READ,  8'h03, 8'h00, 3'd0, 56'h0},
		{8'h00, 8'h00,     8'h00, 8'hFF, 3'd0, 56'h0},
		{8'hA5, 8'h5A,     8'h01, 8'h80, 3'd0, 56'h0},
		{8'h01, INS_REG,   8'h04, 8'h01, 3'd0, 56'h0},
		{8'h02, 8'h02,     8'h02, 8'h02, 3'd0, 56'h0},
		{8'h04, 8'h04,     8'h04, 8'h04, 3'd0, 56'h0},
		{8'h08, 8'h08,     8'h08, 8'h08, 3'd0, 56'h0},
		{8'hFE, INS_ACTION, 8'h00, 8'h7E, 3'd6, 56'hFFFF_FE02_05FA_00}
	};

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	req_item_t req_data = '0;
	logic      tx_valid;
	logic      tx_ready = 1'b0;
	tx_item_t  tx_data;

	// framer model state
	logic       pkt_open = 1'b0;
	logic [7:0] params_due = '0;
	logic [7:0] csum_acc = '0;
	tx_item_t   framed [7];
	int         n_framed;

	tx_item_t tx_expected [$];
	bit       steady = 1'b0;
	int       items_sent = 0;
	int       bytes_checked = 0;
	int       packets_closed = 0;
	int       fails = 0;
	int       cycles = 0;

	servo_instruction_packet_framer dut (
		.clk,
		.arst_n,
		.req_valid,
		.req_ready,
		.req_data,
		.tx_valid,
		.tx_ready,
		.tx_data
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void emit(input logic [7:0] b, input logic eop);
		framed[n_framed] = '{tx_byte: b, end_of_run: 1'b0, end_of_packet: eop};
		n_framed++;
	endfunction

	// Bytes that one transfer on req should produce, in order.
	function automatic void frame_item(input req_item_t it);
		logic [7:0] len;
		n_framed = 0;
		if (!pkt_open) begin
			len = it.param_count + LEN_OFFSET;
			emit(START_BYTE, 1'b0);
			emit(START_BYTE, 1'b0);
			emit(it.servo_id, 1'b0);
			emit(len, 1'b0);
			emit(it.instruction, 1'b0);
			csum_acc = it.servo_id + len + it.instruction;
			if (it.param_count == 8'd0) begin
				emit(~csum_acc, 1'b1);
				csum_acc = '0;
			end else begin
				params_due = it.param_count;
				pkt_open = 1'b1;
			end
		end
		if (pkt_open) begin
			csum_acc += it.param_byte;
			params_due -= 8'd1;
			emit(it.param_byte, 1'b0);
			if (params_due == 8'd0) begin
				emit(~csum_acc, 1'b1);
				pkt_open = 1'b0;
				csum_acc = '0;
			end
		end
		framed[n_framed - 1].end_of_run = 1'b1;
	endfunction

	task automatic send_item(input req_item_t it, input logic [2:0] nbytes,
			input logic [55:0] bytes);
		if (!steady && $urandom_range(0, 99) < STALL_PCT) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= it;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		items_sent++;
		frame_item(it);
		if (nbytes != 3'd0) begin
			for (int k = 0; k < nbytes; k++)
				tx_expected.push_back(tx_item_t'{bytes[55 - 8 * k -: 8],
					k == nbytes - 1, k == nbytes - 1});
		end else begin
			for (int k = 0; k < n_framed; k++)
				tx_expected.push_back(framed[k]);
		end
	endtask

	// Opening item with the given count, then one transfer per remaining parameter;
	// the ignored fields of later items carry noise.
	task automatic send_packet(input logic [7:0] cnt);
		req_item_t it;
		it.servo_id    = 8'($urandom_range(0, 255));
		it.instruction = $urandom_range(0, 1) ? 8'($urandom_range(INS_PING, INS_ACTION))
			: 8'($urandom_range(0, 255));
		it.param_count = cnt;
		it.param_byte  = 8'($urandom_range(0, 255));
		send_item(it, 3'd0, '0);
		for (int k = 1; k < cnt; k++) begin
			it = $urandom();
			send_item(it, 3'd0, '0);
		end
	endtask

	initial begin
		tx_item_t want;
		forever begin
			tx_ready <= steady || ($urandom_range(0, 99) >= STALL_PCT);
			@(posedge clk);
			if (tx_valid && tx_ready) begin
				if (tx_expected.size() == 0) begin
					if (fails < 10)
						$display("unexpected tx transfer: byte %h run end %b packet end %b",
							tx_data.tx_byte, tx_data.end_of_run, tx_data.end_of_packet);
					fails++;
				end else begin
					want = tx_expected.pop_front();
					if (tx_data !== want) begin
						if (fails < 10)
							$display("byte %0d: expected %h/%b/%b, got %h/%b/%b",
								bytes_checked, want.tx_byte, want.end_of_run,
								want.end_of_packet, tx_data.tx_byte,
								tx_data.end_of_run, tx_data.end_of_packet);
						fails++;
					end
					bytes_checked++;
					if (want.end_of_packet) packets_closed++;
				end
			end
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timed out after %0d cycles, %0d bytes outstanding", cycles,
			tx_expected.size());
		$display("FAILURE");
		$finish;
	end

	initial begin
		int random_start;
		int pick;
		logic [7:0] cnt;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int i = 0; i < $size(STIM_ROWS); i++)
			send_item(STIM_ROWS[i].req, STIM_ROWS[i].nbytes, STIM_ROWS[i].bytes);

		random_start = items_sent;
		while (items_sent < random_start + RANDOM_ITEMS) begin
			// opening stretch runs with no idling on either side
			steady = (items_sent < random_start + STEADY_ITEMS);
			pick = $urandom_range(0, 99);
			if (pick < 15)
				cnt = 8'd0;
			else if (pick < 75)
				cnt = 8'($urandom_range(1, 6));
			else if (pick < 95)
				cnt = 8'($urandom_range(7, 20));
			else
				cnt = 8'($urandom_range(21, 60));
			send_packet(cnt);
		end
		steady = 1'b0;
		req_valid <= 1'b0;

		while (tx_expected.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Framed %0d items into %0d packets, counts 0 to 60, idle and steady stretches;",
			items_sent, packets_closed);
		$display("%0d tx bytes compared, %0d mismatches", bytes_checked, fails);
		if (fails == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
